FILE: rtl/bale_pkg.sv
// Shared types and constants for the bounded array list engine.
// No dependencies; used by every module in the rtl folder.
package bale_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned PosW        = 5;
  localparam int unsigned OpW         = 3;
  localparam int unsigned IdxOutW     = 4;
  localparam int unsigned CntOutW     = 5;
  localparam int unsigned InDataW     = 40;
  localparam int unsigned OutDataW    = 48;

  // Request codes carried in the input tuser
  typedef enum logic [OpW-1:0] {
    OP_INSERT     = 3'd0,
    OP_OVERWRITE  = 3'd1,
    OP_READ       = 3'd2,
    OP_FIND       = 3'd3,
    OP_REMOVE_POS = 3'd4,
    OP_REMOVE_VAL = 3'd5
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

endpackage

FILE: rtl/bale_mem.sv
// Element store: single write port, single read port, registered read data.
// Depends on bale_pkg for the data width.
module bale_mem #(
  parameter int unsigned Depth = bale_pkg::DefCapacity,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [bale_pkg::DataW-1:0] wdata_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [bale_pkg::DataW-1:0] rdata_o
);

  logic [bale_pkg::DataW-1:0] mem_q [Depth];
  logic [bale_pkg::DataW-1:0] rdata_q;

  // write port; contents undefined until written
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/bale_step.sv
// Shared step unit: key compare plus read-pointer and write-address stepping.
// Depends on bale_pkg for the data width.
module bale_step #(
  parameter int unsigned Depth = bale_pkg::DefCapacity,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                       dir_up_i,   // 1: walk down, move entries up
  input  logic [AddrW-1:0]           rd_ptr_i,
  input  logic [AddrW-1:0]           last_i,
  input  logic [bale_pkg::DataW-1:0] rdata_i,
  input  logic [bale_pkg::DataW-1:0] key_i,
  output logic [AddrW-1:0]           rd_ptr_nxt_o,
  output logic [AddrW-1:0]           dest_o,
  output logic                       match_o
);

  // next address to read
  assign rd_ptr_nxt_o = dir_up_i ? rd_ptr_i - AddrW'(1) : rd_ptr_i + AddrW'(1);
  // where the word just read lands
  assign dest_o       = dir_up_i ? last_i + AddrW'(1) : last_i - AddrW'(1);
  assign match_o      = (rdata_i == key_i);

endmodule

FILE: rtl/bounded_array_list_engine_core.sv
// Top level of the bounded array list engine: sequencer, count and result register.
// Depends on bale_pkg, bale_mem and bale_step.
//
//  channel   dir  fields (low bit up)
//  s_axis    in   tdata: data_value[31:0], position[36:32]; tuser: opcode[2:0]
//  m_axis    out  tdata: result_value[31:0], match_found[32], match_index[36:33],
//                        status[38:37], item_count[43:39], list_empty[44]
//
// One request at a time. Errors, overwrite and read need no walk; insert or
// remove at position p walks the entries from p to the end of the list; find
// scans from the front up to the first match, and remove value scans and then
// walks the entries after the match. The walk moves one entry per cycle through the single
// read port of the element store. Reset empties the list at once (no clearing
// pass). A result waiting on m_axis_tready holds the sequencer in its response
// step; the next word is still accepted while the previous result waits.
module bounded_array_list_engine_core #(
  parameter int unsigned CAPACITY = bale_pkg::DefCapacity
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [bale_pkg::InDataW-1:0]  s_axis_tdata,  // data_value, position
  input  logic [bale_pkg::OpW-1:0]      s_axis_tuser,  // opcode
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [bale_pkg::OutDataW-1:0] m_axis_tdata   // value, found, index,
                                                       // status, count, empty
);

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW  = (CntW > bale_pkg::PosW) ? CntW : bale_pkg::PosW;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_READ   = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_SCAN   = 6'b010000,
    S_RESP   = 6'b100000
  } state_e;

  state_e                      state_q, state_d;
  logic [CntW-1:0]             count_q, count_d;
  logic                        pend_q, pend_d;
  logic                        m_valid_q, m_valid_d;

  bale_pkg::op_e               op_q, op_d;
  logic [bale_pkg::DataW-1:0]  val_q, val_d;
  logic [bale_pkg::PosW-1:0]   pos_q, pos_d;
  logic [AddrW-1:0]            rd_ptr_q, rd_ptr_d;
  logic [AddrW-1:0]            last_q, last_d;
  logic [AddrW-1:0]            start_q, start_d;
  logic [CntW-1:0]             left_q, left_d;
  logic                        dir_up_q, dir_up_d;
  logic [bale_pkg::DataW-1:0]  rv_q, rv_d;
  logic                        found_q, found_d;
  logic [AddrW-1:0]            midx_q, midx_d;
  bale_pkg::status_e           st_q, st_d;
  logic [bale_pkg::OutDataW-1:0] m_data_q, m_data_d;

  // memory and step unit wiring
  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic [bale_pkg::DataW-1:0]  mem_wdata;
  logic [AddrW-1:0]            mem_raddr;
  logic [bale_pkg::DataW-1:0]  mem_rdata;
  logic [AddrW-1:0]            step_nxt;
  logic [AddrW-1:0]            step_dest;
  logic                        step_match;

  // compare helpers
  logic [CmpW-1:0]             pos_ext, cnt_ext;
  logic                        pos_bad;
  logic [AddrW-1:0]            pos_addr;
  logic [31:0]                 midx_w, cnt_w;

  assign pos_ext  = CmpW'(pos_q);
  assign cnt_ext  = CmpW'(count_q);
  assign pos_bad  = (pos_ext >= cnt_ext);
  assign pos_addr = pos_ext[AddrW-1:0];

  bale_mem #(
    .Depth (CAPACITY)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  bale_step #(
    .Depth (CAPACITY)
  ) u_step (
    .dir_up_i     (dir_up_q),
    .rd_ptr_i     (rd_ptr_q),
    .last_i       (last_q),
    .rdata_i      (mem_rdata),
    .key_i        (val_q),
    .rd_ptr_nxt_o (step_nxt),
    .dest_o       (step_dest),
    .match_o      (step_match)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // sequencer
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    pend_d    = pend_q;
    m_valid_d = m_valid_q & ~m_axis_tready;
    op_d      = op_q;
    val_d     = val_q;
    pos_d     = pos_q;
    rd_ptr_d  = rd_ptr_q;
    last_d    = last_q;
    start_d   = start_q;
    left_d    = left_q;
    dir_up_d  = dir_up_q;
    rv_d      = rv_q;
    found_d   = found_q;
    midx_d    = midx_q;
    st_d      = st_q;
    m_data_d  = m_data_q;
    mem_we    = 1'b0;
    mem_waddr = pos_addr;
    mem_wdata = val_q;
    mem_raddr = rd_ptr_q;
    midx_w    = 32'(midx_q);
    cnt_w     = 32'(count_q);

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d    = bale_pkg::op_e'(s_axis_tuser);
          val_d   = s_axis_tdata[bale_pkg::DataW-1:0];
          pos_d   = s_axis_tdata[bale_pkg::DataW +: bale_pkg::PosW];
          state_d = S_DECODE;
        end
      end

      S_DECODE: begin
        rv_d     = '0;
        found_d  = 1'b0;
        midx_d   = '0;
        st_d     = bale_pkg::ST_OK;
        pend_d   = 1'b0;
        dir_up_d = 1'b0;
        unique case (op_q)
          bale_pkg::OP_INSERT: begin
            if (count_q == CntW'(CAPACITY)) begin
              st_d    = bale_pkg::ST_FULL;
              state_d = S_RESP;
            end else if (pos_ext > cnt_ext) begin
              st_d    = bale_pkg::ST_BADPOS;
              state_d = S_RESP;
            end else begin
              dir_up_d = 1'b1;
              left_d   = CntW'(cnt_ext - pos_ext);
              rd_ptr_d = AddrW'(count_q - CntW'(1));
              state_d  = S_SHIFT;
            end
          end
          bale_pkg::OP_OVERWRITE: begin
            if (pos_bad) begin
              st_d = bale_pkg::ST_BADPOS;
            end else begin
              mem_we = 1'b1;
            end
            state_d = S_RESP;
          end
          bale_pkg::OP_READ: begin
            mem_raddr = pos_addr;
            if (pos_bad) begin
              st_d    = bale_pkg::ST_BADPOS;
              state_d = S_RESP;
            end else begin
              state_d = S_READ;
            end
          end
          bale_pkg::OP_FIND, bale_pkg::OP_REMOVE_VAL: begin
            left_d   = count_q;
            rd_ptr_d = '0;
            state_d  = S_SCAN;
          end
          bale_pkg::OP_REMOVE_POS: begin
            if (pos_bad) begin
              st_d    = bale_pkg::ST_BADPOS;
              state_d = S_RESP;
            end else begin
              left_d   = CntW'(cnt_ext - pos_ext);
              rd_ptr_d = pos_addr;
              start_d  = pos_addr;
              state_d  = S_SHIFT;
            end
          end
          default: begin
            st_d    = bale_pkg::ST_BADPOS;
            state_d = S_RESP;
          end
        endcase
      end

      // registered read data arrives in the cycle after the address
      S_READ: begin
        rv_d    = mem_rdata;
        state_d = S_RESP;
      end

      // move entries one place; reads overlap the writes of the word before
      S_SHIFT: begin
        if (pend_q) begin
          if (dir_up_q) begin
            mem_we    = 1'b1;
            mem_waddr = step_dest;
            mem_wdata = mem_rdata;
          end else if (last_q == start_q) begin
            rv_d = mem_rdata;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = step_dest;
            mem_wdata = mem_rdata;
          end
        end
        if (left_q != '0) begin
          last_d   = rd_ptr_q;
          rd_ptr_d = step_nxt;
          left_d   = left_q - CntW'(1);
          pend_d   = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
        if (!pend_q && left_q == '0) begin
          if (dir_up_q) begin
            mem_we  = 1'b1;
            count_d = count_q + CntW'(1);
          end else begin
            count_d = count_q - CntW'(1);
          end
          state_d = S_RESP;
        end
      end

      // walk from the front for the first equal entry
      S_SCAN: begin
        if (pend_q && step_match) begin
          found_d = 1'b1;
          midx_d  = last_q;
          pend_d  = 1'b0;
          if (op_q == bale_pkg::OP_FIND) begin
            state_d = S_RESP;
          end else begin
            left_d   = count_q - CntW'(last_q);
            rd_ptr_d = last_q;
            start_d  = last_q;
            state_d  = S_SHIFT;
          end
        end else if (left_q != '0) begin
          last_d   = rd_ptr_q;
          rd_ptr_d = step_nxt;
          left_d   = left_q - CntW'(1);
          pend_d   = 1'b1;
        end else if (!pend_q) begin
          st_d    = bale_pkg::ST_NOTFOUND;
          state_d = S_RESP;
        end else begin
          pend_d = 1'b0;
        end
      end

      // load the result word once the output register is free
      S_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          m_data_d  = {3'b000,
                       (count_q == '0),
                       cnt_w[bale_pkg::CntOutW-1:0],
                       st_q,
                       midx_w[bale_pkg::IdxOutW-1:0],
                       found_q,
                       rv_q};
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      m_valid_q <= m_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    val_q    <= val_d;
    pos_q    <= pos_d;
    rd_ptr_q <= rd_ptr_d;
    last_q   <= last_d;
    start_q  <= start_d;
    left_q   <= left_d;
    dir_up_q <= dir_up_d;
    rv_q     <= rv_d;
    found_q  <= found_d;
    midx_q   <= midx_d;
    st_q     <= st_d;
    m_data_q <= m_data_d;
  end

endmodule

FILE: bench/bounded_array_list_engine_core_tb.sv
// Self-checking testbench for bounded_array_list_engine_core: directed, fill and random traffic,
// each word checked against a cycle-free list predictor. Depends on bale_pkg and the core RTL.
module bounded_array_list_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DataW        = bale_pkg::DataW;
  localparam int unsigned PosW         = bale_pkg::PosW;
  localparam int unsigned OpW          = bale_pkg::OpW;
  localparam int unsigned IdxOutW      = bale_pkg::IdxOutW;
  localparam int unsigned CntOutW      = bale_pkg::CntOutW;
  localparam int unsigned InDataW      = bale_pkg::InDataW;
  localparam int unsigned OutDataW     = bale_pkg::OutDataW;
  localparam int unsigned Cap          = bale_pkg::DefCapacity;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned MaxReports   = 10;
  // Codes outside the operation set; the block answers them as an illegal position
  localparam logic [OpW-1:0] OpSpare6  = 3'd6;
  localparam logic [OpW-1:0] OpSpare7  = 3'd7;

  typedef struct {
    logic [DataW-1:0]   value;
    logic               found;
    logic [IdxOutW-1:0] index;
    bale_pkg::status_e  status;
    logic [CntOutW-1:0] count;
    logic               empty;
  } list_result_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;  // data_value[31:0], position[36:32]
  logic [OpW-1:0]      s_axis_tuser  = '0;  // opcode[2:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;        // value, found, index, status, count, empty

  // Predicted list contents and the results still owed by the block
  logic [DataW-1:0] list_mem [Cap];
  int unsigned      list_len = 0;
  list_result_t     pending_results[$];

  int gap_pct    = 0;
  int stall_pct  = 0;
  int fail_count = 0;
  int word_count = 0;

  bounded_array_list_engine_core #(.CAPACITY(Cap)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Pull the entry at a position out of the list, closing the gap
  function automatic logic [DataW-1:0] take_entry(int unsigned at);
    logic [DataW-1:0] v;
    v = list_mem[at];
    for (int unsigned i = at + 1; i < list_len; i++) list_mem[i-1] = list_mem[i];
    list_len--;
    return v;
  endfunction

  // Apply one request to the predicted list and return the result it gives
  function automatic list_result_t predict_list_op(logic [OpW-1:0] op, logic [DataW-1:0] val,
                                                   logic [PosW-1:0] pos);
    list_result_t r;
    int unsigned  hit;
    r.value  = '0;
    r.found  = 1'b0;
    r.index  = '0;
    r.status = bale_pkg::ST_OK;
    // first (lowest) matching entry, or list_len when none
    hit = list_len;
    for (int unsigned i = 0; i < list_len; i++) begin
      if (hit == list_len && list_mem[i] == val) hit = i;
    end
    case (op)
      bale_pkg::OP_INSERT: begin
        if (list_len >= Cap) begin
          r.status = bale_pkg::ST_FULL;
        end else if (pos > list_len) begin
          r.status = bale_pkg::ST_BADPOS;
        end else begin
          for (int unsigned i = list_len; i > pos; i--) list_mem[i] = list_mem[i-1];
          list_mem[pos] = val;
          list_len++;
        end
      end
      bale_pkg::OP_OVERWRITE: begin
        if (pos >= list_len) r.status = bale_pkg::ST_BADPOS;
        else list_mem[pos] = val;
      end
      bale_pkg::OP_READ: begin
        if (pos >= list_len) r.status = bale_pkg::ST_BADPOS;
        else r.value = list_mem[pos];
      end
      bale_pkg::OP_FIND, bale_pkg::OP_REMOVE_VAL: begin
        if (hit >= list_len) begin
          r.status = bale_pkg::ST_NOTFOUND;
        end else begin
          r.found = 1'b1;
          r.index = IdxOutW'(hit);
          if (op == bale_pkg::OP_REMOVE_VAL) r.value = take_entry(hit);
        end
      end
      bale_pkg::OP_REMOVE_POS: begin
        if (pos >= list_len) r.status = bale_pkg::ST_BADPOS;
        else r.value = take_entry(pos);
      end
      default: begin
        r.status = bale_pkg::ST_BADPOS;
      end
    endcase
    r.count = CntOutW'(list_len);
    r.empty = (list_len == 0);
    return r;
  endfunction

  // Mix of extremes, a small pool that makes duplicates, and full-range values
  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'hFFFF_FFFF;
      3: return '0;
      4, 5, 6: return DataW'($urandom_range(5));
      default: return $urandom();
    endcase
  endfunction

  // Offer one request word, with random idle cycles first; tvalid stays high on return
  task automatic send_request(logic [OpW-1:0] op, logic [DataW-1:0] val, logic [PosW-1:0] pos);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InDataW-PosW-DataW){1'b0}}, pos, val};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(predict_list_op(op, val, pos));
  endtask

  // Empty-list errors, both ends of the value range, duplicates, spare codes
  task automatic test_directed_ops();
    send_request(bale_pkg::OP_READ,       '0,            5'd0);
    send_request(bale_pkg::OP_REMOVE_POS, '0,            5'd0);
    send_request(bale_pkg::OP_FIND,       32'd5,         5'd0);
    send_request(bale_pkg::OP_REMOVE_VAL, 32'd5,         5'd0);
    send_request(bale_pkg::OP_INSERT,     32'd9,         5'd1);
    send_request(bale_pkg::OP_INSERT,     32'h8000_0000, 5'd0);
    send_request(bale_pkg::OP_INSERT,     32'h7FFF_FFFF, 5'd1);
    send_request(bale_pkg::OP_INSERT,     32'hFFFF_FFFF, 5'd0);
    send_request(bale_pkg::OP_INSERT,     32'h7FFF_FFFF, 5'd1);
    // two equal entries: the lower one must be reported
    send_request(bale_pkg::OP_FIND,       32'h7FFF_FFFF, 5'd0);
    send_request(bale_pkg::OP_OVERWRITE,  32'd0,         5'd3);
    send_request(bale_pkg::OP_OVERWRITE,  32'd1,         5'd4);
    send_request(bale_pkg::OP_READ,       '0,            5'd3);
    send_request(bale_pkg::OP_READ,       '0,            5'd0);
    send_request(bale_pkg::OP_INSERT,     32'h55AA_55AA, 5'd4);
    send_request(bale_pkg::OP_INSERT,     32'h1,         5'd31);
    send_request(OpSpare6,                32'hFFFF_FFFF, 5'd31);
    send_request(OpSpare7,                32'hFFFF_FFFF, 5'd0);
    send_request(bale_pkg::OP_REMOVE_VAL, 32'h7FFF_FFFF, 5'd0);
    send_request(bale_pkg::OP_REMOVE_POS, '0,            5'd0);
    send_request(bale_pkg::OP_REMOVE_POS, '0,            5'd2);
    send_request(bale_pkg::OP_READ,       '0,            5'd2);
    send_request(bale_pkg::OP_REMOVE_VAL, 32'd0,         5'd0);
    send_request(bale_pkg::OP_REMOVE_POS, '0,            5'd0);
    send_request(bale_pkg::OP_FIND,       32'h8000_0000, 5'd0);
  endtask

  // Fill to capacity, hit the full cases (fullness wins over a bad position), drain again
  task automatic test_fill_and_overflow();
    while (list_len < Cap)
      send_request(bale_pkg::OP_INSERT, pick_value(), PosW'($urandom_range(list_len)));
    send_request(bale_pkg::OP_INSERT, 32'h1234_5678, 5'd0);
    send_request(bale_pkg::OP_INSERT, 32'h1234_5678, 5'd31);
    send_request(bale_pkg::OP_READ, '0, PosW'(Cap - 1));
    send_request(bale_pkg::OP_READ, '0, PosW'(Cap));
    send_request(bale_pkg::OP_FIND, list_mem[Cap-1], 5'd0);
    while (list_len != 0) begin
      if ($urandom_range(1))
        send_request(bale_pkg::OP_REMOVE_VAL, list_mem[$urandom_range(list_len - 1)], 5'd0);
      else
        send_request(bale_pkg::OP_REMOVE_POS, pick_value(),
                     PosW'($urandom_range(list_len - 1)));
    end
  endtask

  // Random requests that sweep the fill level between empty and full
  task automatic test_random_traffic(int n_items, int gap, int stall);
    logic [OpW-1:0]   op;
    logic [DataW-1:0] val;
    logic [PosW-1:0]  pos;
    int unsigned      fill_target;
    int unsigned      ins_w;
    int unsigned      rem_w;
    int unsigned      pick;
    gap_pct     = gap;
    stall_pct   = stall;
    fill_target = 0;
    for (int k = 0; k < n_items; k++) begin
      if (k % 32 == 0) begin
        case ($urandom_range(3))
          0: fill_target = 0;
          1: fill_target = Cap;
          default: fill_target = $urandom_range(Cap);
        endcase
      end
      ins_w = (list_len < fill_target) ? 40 : 8;
      rem_w = (list_len > fill_target) ? 20 : 5;
      pick  = $urandom_range(ins_w + 2 * rem_w + 44);
      if (pick < ins_w) begin
        op = bale_pkg::OP_INSERT;
      end else if (pick < ins_w + rem_w) begin
        op = bale_pkg::OP_REMOVE_POS;
      end else if (pick < ins_w + 2 * rem_w) begin
        op = bale_pkg::OP_REMOVE_VAL;
      end else begin
        pick -= ins_w + 2 * rem_w;
        if (pick < 12) op = bale_pkg::OP_OVERWRITE;
        else if (pick < 26) op = bale_pkg::OP_READ;
        else if (pick < 42) op = bale_pkg::OP_FIND;
        else op = $urandom_range(1) ? OpSpare6 : OpSpare7;
      end
      // searches mostly look for a value that is held
      if ((op == bale_pkg::OP_FIND || op == bale_pkg::OP_REMOVE_VAL) && list_len != 0 &&
          $urandom_range(9) < 7)
        val = list_mem[$urandom_range(list_len - 1)];
      else
        val = pick_value();
      // positions mostly legal, now and then anywhere in the field
      if ($urandom_range(11) == 0) pos = PosW'($urandom_range(31));
      else if (op == bale_pkg::OP_INSERT) pos = PosW'($urandom_range(list_len));
      else if (list_len != 0) pos = PosW'($urandom_range(list_len - 1));
      else pos = '0;
      send_request(op, val, pos);
    end
  endtask

  // Result side: random back-pressure and a field-by-field check of every word taken
  initial begin
    list_result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        word_count++;
        if (pending_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MaxReports)
            $display("word %0d: result with nothing pending: %h", word_count, m_axis_tdata);
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[31:0] !== want.value || m_axis_tdata[32] !== want.found ||
              m_axis_tdata[36:33] !== want.index || m_axis_tdata[38:37] !== want.status ||
              m_axis_tdata[43:39] !== want.count || m_axis_tdata[44] !== want.empty ||
              m_axis_tdata[47:45] !== 3'b000) begin
            fail_count++;
            if (fail_count <= MaxReports)
              $display({"word %0d mismatch: expected value %h found %b index %0d status %0d",
                        " count %0d empty %b; got value %h found %b index %0d status %0d",
                        " count %0d empty %b pad %b"},
                       word_count, want.value, want.found, want.index, want.status,
                       want.count, want.empty, m_axis_tdata[31:0], m_axis_tdata[32],
                       m_axis_tdata[36:33], m_axis_tdata[38:37], m_axis_tdata[43:39],
                       m_axis_tdata[44], m_axis_tdata[47:45]);
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  // Sequence of tests
  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_ops();
    test_fill_and_overflow();
    test_random_traffic(180, 0, 0);
    test_random_traffic(170, 70, 0);
    test_random_traffic(170, 0, 70);
    test_random_traffic(170, 31, 31);
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
